/* rtl/alsc_pkg.sv */
`timescale 1ns / 1ps

package alsc_pkg;

    localparam int PC_W      = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int DIV_W     = 39;    // 15-bit change magnitude shifted left by 24
    localparam int CNT_W     = 6;

    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIV_W);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_TOL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANGE    = 3'd4;

    localparam logic [7:0]  TARGET_RATE_RST   = 8'd60;
    localparam logic [7:0]  RATE_TOL_RST      = 8'd5;
    localparam logic [23:0] UPDATE_PERIOD_RST = 24'd500000;
    localparam logic [15:0] FALLBACK_GAIN_RST = 16'd256;
    localparam logic [14:0] MAX_CHANGE_RST    = 15'd100;

    localparam logic [24:0] ELAPSED_MAX = 25'h1FFFFFF;
    localparam logic [31:0] GAIN_TINY   = 32'd7;     // below 0.0001 in Q16.16
    localparam logic [31:0] GAIN_SUBST  = 32'd655;   // 0.01 in Q16.16

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_ACCUM,
        OP_NOP,
        OP_CLR_TIME,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_MUL,
        OP_CLAMP,
        OP_ZERO,
        OP_PUSH
    } op_t;

    typedef enum logic [3:0] {
        CS_NEVER,
        CS_ALWAYS,
        CS_NO_ITEM,
        CS_NOT_DUE,
        CS_NO_PENDING,
        CS_SMALL_DIP,
        CS_COUNT_LEFT,
        CS_IN_BAND,
        CS_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // Program addresses
    localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] PC_ACCUM = 4'd1;
    localparam logic [PC_W-1:0] PC_DUE   = 4'd2;
    localparam logic [PC_W-1:0] PC_CLR   = 4'd3;
    localparam logic [PC_W-1:0] PC_DINIT = 4'd4;
    localparam logic [PC_W-1:0] PC_DSTEP = 4'd5;
    localparam logic [PC_W-1:0] PC_DEND  = 4'd6;
    localparam logic [PC_W-1:0] PC_BAND  = 4'd7;
    localparam logic [PC_W-1:0] PC_MUL   = 4'd8;
    localparam logic [PC_W-1:0] PC_CLAMP = 4'd9;
    localparam logic [PC_W-1:0] PC_ZERO  = 4'd10;
    localparam logic [PC_W-1:0] PC_PUSH  = 4'd11;
    localparam logic [PC_W-1:0] PC_LAST  = PC_PUSH;

    // Control store. The jump is taken when the condition holds, else the
    // step counter advances, wrapping after the last word.
    function automatic ctrl_t ucode(input logic [PC_W-1:0] addr);
        ctrl_t w;
        w = '{op: OP_NOP, cond: CS_ALWAYS, target: PC_WAIT};
        unique case (addr)
            PC_WAIT:  w = '{op: OP_LOAD,     cond: CS_NO_ITEM,    target: PC_WAIT};
            PC_ACCUM: w = '{op: OP_ACCUM,    cond: CS_NEVER,      target: PC_WAIT};
            PC_DUE:   w = '{op: OP_NOP,      cond: CS_NOT_DUE,    target: PC_ZERO};
            PC_CLR:   w = '{op: OP_CLR_TIME, cond: CS_NO_PENDING, target: PC_BAND};
            PC_DINIT: w = '{op: OP_DIV_INIT, cond: CS_SMALL_DIP,  target: PC_BAND};
            PC_DSTEP: w = '{op: OP_DIV_STEP, cond: CS_COUNT_LEFT, target: PC_DSTEP};
            PC_DEND:  w = '{op: OP_DIV_END,  cond: CS_NEVER,      target: PC_WAIT};
            PC_BAND:  w = '{op: OP_NOP,      cond: CS_IN_BAND,    target: PC_ZERO};
            PC_MUL:   w = '{op: OP_MUL,      cond: CS_NEVER,      target: PC_WAIT};
            PC_CLAMP: w = '{op: OP_CLAMP,    cond: CS_ALWAYS,     target: PC_PUSH};
            PC_ZERO:  w = '{op: OP_ZERO,     cond: CS_NEVER,      target: PC_WAIT};
            PC_PUSH:  w = '{op: OP_PUSH,     cond: CS_OUT_BUSY,   target: PC_PUSH};
            default:  w = '{op: OP_NOP,      cond: CS_ALWAYS,     target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

/* rtl/adaptive_load_step_controller.sv */
`timescale 1ns / 1ps

// Adaptive load step controller. Each transfer on the s_ channel carries one
// frame rate sample (unsigned Q8.8) and the frame time in microseconds; each
// produces exactly one signed load_change on the m_ channel, zero unless an
// update period has elapsed and the running rate average lies outside the
// band target - tolerance .. target + 2 * tolerance. A small microcoded
// sequencer runs every item through one shared datapath: an item with no
// decision due skips the decision steps, and only a gain re-estimation
// runs the one-bit-per-cycle restoring divider (39 quotient bits). The
// next item is taken as soon as the previous result sits in the output
// register.
// Configuration writes on the cfg_ channel are always accepted and must be
// issued only while the block is idle.
module adaptive_load_step_controller
    import alsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          s_frame_rate,
    input  logic [19:0]          s_frame_time_us,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_load_change,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // Configuration
    logic [7:0]  target_rate_reg;
    logic [7:0]  rate_tol_reg;
    logic [23:0] update_period_reg;
    logic [15:0] fallback_gain_reg;
    logic [14:0] max_change_reg;

    // Sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_t           ctrl;
    logic            cond_hit;

    // Datapath registers
    logic [15:0]        rate_in_reg, rate_in_next;
    logic [19:0]        time_in_reg, time_in_next;
    logic [15:0]        avg_rate_reg, avg_rate_next;
    logic [24:0]        elapsed_reg, elapsed_next;
    logic               change_pending_reg, change_pending_next;
    logic [15:0]        rate_before_reg, rate_before_next;
    logic [31:0]        gain_reg, gain_next;
    logic signed [15:0] last_change_reg, last_change_next;
    logic [15:0]        divisor_reg, divisor_next;
    logic [15:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [47:0]        product_reg, product_next;
    logic               neg_reg, neg_next;
    logic signed [15:0] result_reg, result_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] m_change_reg, m_change_next;

    // Datapath logic
    logic        accept_in;
    logic        out_free;
    logic [16:0] avg_sum;
    logic [25:0] elapsed_sum;
    logic        due;
    logic [16:0] dip;
    logic [16:0] dip_abs;
    logic [15:0] dip_mag;
    logic        small_dip;
    logic [15:0] lc_abs;
    logic [14:0] lc_mag;
    logic [16:0] trial;
    logic        fits;
    logic [16:0] trial_sub;
    logic [31:0] quo_sat;
    logic [18:0] band_lo;
    logic [18:0] band_hi;
    logic [18:0] avg_ext;
    logic        in_band;
    logic [16:0] dev;
    logic [16:0] dev_abs;
    logic [15:0] dev_mag;
    logic [31:0] gain_eff;
    logic [23:0] step_raw;
    logic [14:0] step_mag;
    logic [15:0] change;

    assign ctrl      = ucode(pc_reg);
    assign s_ready   = (ctrl.op == OP_LOAD);
    assign accept_in = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_load_change = m_change_reg;

    always_comb begin
        avg_sum     = {1'b0, avg_rate_reg} + {1'b0, rate_in_reg};
        elapsed_sum = {1'b0, elapsed_reg} + {6'd0, time_in_reg};
        due         = elapsed_reg > {1'b0, update_period_reg};

        dip       = {1'b0, rate_before_reg} - {1'b0, avg_rate_reg};
        dip_abs   = dip[16] ? (17'd0 - dip) : dip;
        dip_mag   = dip_abs[15:0];
        small_dip = dip_mag < fallback_gain_reg;

        lc_abs = last_change_reg[15] ? (16'd0 - last_change_reg) : last_change_reg;
        lc_mag = lc_abs[14:0];

        // A zero divisor always fits, so the quotient fills with ones and
        // saturates below.
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = trial >= {1'b0, divisor_reg};
        trial_sub = trial - {1'b0, divisor_reg};
        quo_sat   = (quo_reg[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : quo_reg[31:0];

        band_lo = ({11'd0, target_rate_reg} - {11'd0, rate_tol_reg}) << 8;
        band_hi = ({11'd0, target_rate_reg} + {10'd0, rate_tol_reg, 1'b0}) << 8;
        avg_ext = {3'd0, avg_rate_reg};
        in_band = !(($signed(avg_ext) < $signed(band_lo)) ||
                    ($signed(avg_ext) > $signed(band_hi)));

        dev      = {1'b0, avg_rate_reg} - {1'b0, target_rate_reg, 8'd0};
        dev_abs  = dev[16] ? (17'd0 - dev) : dev;
        dev_mag  = dev_abs[15:0];
        gain_eff = (gain_reg < GAIN_TINY) ? GAIN_SUBST : gain_reg;

        step_raw = product_reg[47:24];
        step_mag = (step_raw > {9'd0, max_change_reg}) ? max_change_reg : step_raw[14:0];
        change   = neg_reg ? (16'd0 - {1'b0, step_mag}) : {1'b0, step_mag};
    end

    always_comb begin
        case (ctrl.cond)
            CS_NEVER:      cond_hit = 1'b0;
            CS_ALWAYS:     cond_hit = 1'b1;
            CS_NO_ITEM:    cond_hit = !s_valid;
            CS_NOT_DUE:    cond_hit = !due;
            CS_NO_PENDING: cond_hit = !change_pending_reg;
            CS_SMALL_DIP:  cond_hit = small_dip;
            CS_COUNT_LEFT: cond_hit = (count_reg != CNT_W'(1));
            CS_IN_BAND:    cond_hit = in_band;
            CS_OUT_BUSY:   cond_hit = !out_free;
            default:       cond_hit = 1'b0;
        endcase
        if (cond_hit) begin
            pc_next = ctrl.target;
        end else if (pc_reg == PC_LAST) begin
            pc_next = PC_WAIT;
        end else begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_comb begin
        rate_in_next        = rate_in_reg;
        time_in_next        = time_in_reg;
        avg_rate_next       = avg_rate_reg;
        elapsed_next        = elapsed_reg;
        change_pending_next = change_pending_reg;
        rate_before_next    = rate_before_reg;
        gain_next           = gain_reg;
        last_change_next    = last_change_reg;
        divisor_next        = divisor_reg;
        rem_next            = rem_reg;
        quo_next            = quo_reg;
        count_next          = count_reg;
        product_next        = product_reg;
        neg_next            = neg_reg;
        result_next         = result_reg;
        m_change_next       = m_change_reg;
        m_valid_next        = m_valid_reg && !m_ready;

        unique case (ctrl.op)
            OP_LOAD: begin
                if (accept_in) begin
                    rate_in_next = s_frame_rate;
                    time_in_next = s_frame_time_us;
                end
            end
            OP_ACCUM: begin
                avg_rate_next = avg_sum[16:1];
                elapsed_next  = elapsed_sum[25] ? ELAPSED_MAX : elapsed_sum[24:0];
            end
            OP_NOP: begin
            end
            OP_CLR_TIME: begin
                elapsed_next = '0;
            end
            OP_DIV_INIT: begin
                if (small_dip) begin
                    gain_next           = {8'd0, fallback_gain_reg, 8'd0};
                    change_pending_next = 1'b0;
                end else begin
                    divisor_next = dip_mag;
                    rem_next     = '0;
                    quo_next     = {lc_mag, 24'd0};
                    count_next   = DIV_STEPS;
                end
            end
            OP_DIV_STEP: begin
                quo_next   = {quo_reg[DIV_W-2:0], fits};
                rem_next   = fits ? trial_sub[15:0] : trial[15:0];
                count_next = count_reg - CNT_W'(1);
            end
            OP_DIV_END: begin
                gain_next           = quo_sat;
                change_pending_next = 1'b0;
            end
            OP_MUL: begin
                product_next = gain_eff * {16'd0, dev_mag};
                neg_next     = dev[16];
            end
            OP_CLAMP: begin
                last_change_next    = change;
                result_next         = change;
                rate_before_next    = avg_rate_reg;
                change_pending_next = 1'b1;
            end
            OP_ZERO: begin
                result_next = '0;
            end
            OP_PUSH: begin
                if (out_free) begin
                    m_change_next = result_reg;
                    m_valid_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_rate_reg   <= TARGET_RATE_RST;
            rate_tol_reg      <= RATE_TOL_RST;
            update_period_reg <= UPDATE_PERIOD_RST;
            fallback_gain_reg <= FALLBACK_GAIN_RST;
            max_change_reg    <= MAX_CHANGE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TARGET_RATE:   target_rate_reg   <= cfg_data[7:0];
                REG_RATE_TOL:      rate_tol_reg      <= cfg_data[7:0];
                REG_UPDATE_PERIOD: update_period_reg <= cfg_data[23:0];
                REG_FALLBACK_GAIN: fallback_gain_reg <= cfg_data[15:0];
                REG_MAX_CHANGE:    max_change_reg    <= cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg             <= PC_WAIT;
            m_valid_reg        <= 1'b0;
            avg_rate_reg       <= '0;
            elapsed_reg        <= '0;
            change_pending_reg <= 1'b0;
            rate_before_reg    <= '0;
            gain_reg           <= '0;
            last_change_reg    <= '0;
            count_reg          <= '0;
        end else begin
            pc_reg             <= pc_next;
            m_valid_reg        <= m_valid_next;
            avg_rate_reg       <= avg_rate_next;
            elapsed_reg        <= elapsed_next;
            change_pending_reg <= change_pending_next;
            rate_before_reg    <= rate_before_next;
            gain_reg           <= gain_next;
            last_change_reg    <= last_change_next;
            count_reg          <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        rate_in_reg  <= rate_in_next;
        time_in_reg  <= time_in_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        product_reg  <= product_next;
        neg_reg      <= neg_next;
        result_reg   <= result_next;
        m_change_reg <= m_change_next;
    end

    // The step counter never leaves the program.
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= PC_LAST)
        else $error("sequencer left the control store");

    // The divider never runs with an exhausted bit count.
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_DIV_STEP) |-> (count_reg != '0))
        else $error("divider step with zero count");

    // An accepted item always starts the accumulate step next.
    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_in |=> (pc_reg == PC_ACCUM))
        else $error("accepted item not processed");

    // A recorded change never exceeds the configured limit.
    a_change_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(ctrl.op == OP_CLAMP) |-> ({1'b0, lc_mag} <= {1'b0, max_change_reg}))
        else $error("recorded change above limit");

    // A change becomes pending only through the clamp step.
    a_pending_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(change_pending_reg) |-> $past(ctrl.op == OP_CLAMP))
        else $error("pending flag set outside clamp step");

endmodule

/* dv/adaptive_load_step_controller_tb.sv */
`timescale 1ns / 1ps

module adaptive_load_step_controller_tb;
    import alsc_pkg::*;

    localparam int QUIET_LIMIT  = 20000;
    localparam int SETTLE_TICKS = 60;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 8;

    // Indexes that decode to no register.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DAT_W-1:0]  value;     // frame rate on sample rows
        logic [19:0]           time_us;
        logic                  known;
        logic signed [15:0]    want;
    } plan_row_t;

    localparam plan_row_t PLAN [32] = '{
        '{ROW_SAMPLE, '0, 24'h000000, 20'd0,       1'b1, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h00FFFF, 20'd1000000, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h000000, 20'd1000000, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h000000, 20'd0,       1'b1, 16'sd0},
        '{ROW_WRITE, REG_FALLBACK_GAIN, 24'hFFFFFF, 20'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_MAX_CHANGE,    24'hFFFFFF, 20'd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h000000, 20'd1000000, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h000000, 20'd1000000, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_FALLBACK_GAIN, 24'h000001, 20'd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'd1947,   20'd1000000, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'd1997,   20'd1000000, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_FALLBACK_GAIN, 24'h000000, 20'd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'd1997,   20'd1000000, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_UNMAPPED_LO,   24'hFFFFFF, 20'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_UNMAPPED_HI,   24'h5A5A5A, 20'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_MAX_CHANGE,    24'h000000, 20'd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h00FFFF, 20'd1000000, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_UPDATE_PERIOD, 24'h000000, 20'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_MAX_CHANGE,    24'd100,    20'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_FALLBACK_GAIN, 24'd256,    20'd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h00AAAA, 20'hAAAAA,   1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h005555, 20'h55555,   1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h000001, 20'd1,       1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h008000, 20'd0,       1'b1, 16'sd0},
        '{ROW_WRITE, REG_TARGET_RATE,   24'hFFFFFF, 20'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_RATE_TOL,      24'h000000, 20'd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h00FFFF, 20'd1000000, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_TARGET_RATE,   24'h000000, 20'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_RATE_TOL,      24'h0000FF, 20'd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h000000, 20'd1000000, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_UPDATE_PERIOD, 24'hFFFFFF, 20'd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, '0, 24'h00FFFF, 20'd1000000, 1'b1, 16'sd0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [15:0]           s_frame_rate = '0;
    logic [19:0]           s_frame_time_us = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [15:0]    m_load_change;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    logic signed [15:0] due_changes [$];

    // Predictor copy of the register file and of the controller state.
    logic [7:0]         set_target;
    logic [7:0]         set_tol;
    logic [23:0]        set_period;
    logic [15:0]        set_fallback;
    logic [14:0]        set_max_change;
    logic [15:0]        avg_q;
    logic [24:0]        elapsed_q;
    bit                 pending_q;
    logic [15:0]        rate_at_change;
    logic [31:0]        gain_q;
    logic signed [15:0] change_q;

    adaptive_load_step_controller u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frame_rate    (s_frame_rate),
        .s_frame_time_us (s_frame_time_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_load_change   (m_load_change),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [15:0] next_load_change(input logic [15:0] rate,
                                                            input logic [19:0] t);
        logic [16:0] rate_sum;
        logic [25:0] time_sum;
        int          dip;
        int          dev;
        int          lo;
        int          hi;
        logic [31:0] dip_mag;
        logic [31:0] dev_mag;
        logic [31:0] g;
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] prod;
        rate_sum = avg_q + rate;
        avg_q = rate_sum[16:1];
        time_sum = elapsed_q + t;
        elapsed_q = (time_sum > ELAPSED_MAX) ? ELAPSED_MAX : time_sum[24:0];
        if (elapsed_q > set_period) begin
            elapsed_q = '0;
            if (pending_q) begin
                // Gain is the last change over the rate dip it caused, in Q16.16.
                dip = int'(rate_at_change) - int'(avg_q);
                dip_mag = (dip < 0) ? -dip : dip;
                if (dip_mag < set_fallback) begin
                    gain_q = {8'd0, set_fallback, 8'd0};
                end else if (dip_mag == 0) begin
                    gain_q = '1;
                end else begin
                    num = (change_q < 0) ? -64'(change_q) : 64'(change_q);
                    quo = (num << 24) / dip_mag;
                    gain_q = (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
                end
                pending_q = 1'b0;
            end
            lo = (int'(set_target) - int'(set_tol)) * 256;
            hi = (int'(set_target) + 2 * int'(set_tol)) * 256;
            if (int'(avg_q) < lo || int'(avg_q) > hi) begin
                g = (gain_q < GAIN_TINY) ? GAIN_SUBST : gain_q;
                dev = int'(avg_q) - int'(set_target) * 256;
                dev_mag = (dev < 0) ? -dev : dev;
                prod = (64'(g) * 64'(dev_mag)) >> 24;
                if (prod > set_max_change) begin
                    prod = set_max_change;
                end
                change_q = (dev < 0) ? -16'(prod) : 16'(prod);
                rate_at_change = avg_q;
                pending_q = 1'b1;
                return change_q;
            end
        end
        return 16'sd0;
    endfunction

    task automatic send_sample(input logic [15:0] rate, input logic [19:0] t,
                               input bit known, input logic signed [15:0] want);
        logic signed [15:0] predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_frame_rate <= rate;
        s_frame_time_us <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = next_load_change(rate, t);
        due_changes.push_back(known ? want : predicted);
    endtask

    // Leaves cfg_valid high so that back-to-back writes need no gap.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_TARGET_RATE:   set_target = data[7:0];
            REG_RATE_TOL:      set_tol = data[7:0];
            REG_UPDATE_PERIOD: set_period = data[23:0];
            REG_FALLBACK_GAIN: set_fallback = data[15:0];
            REG_MAX_CHANGE:    set_max_change = data[14:0];
            default: ;
        endcase
    endtask

    task automatic drain_changes();
        if (s_valid) begin
            s_valid <= 1'b0;
        end
        while (due_changes.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        logic signed [15:0] want;
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_changes.size() == 0) begin
                    $display("%0t: load_change %0d arrived with nothing expected",
                             $time, m_load_change);
                    mismatches++;
                end else begin
                    want = due_changes.pop_front();
                    if (m_load_change !== want) begin
                        $display("%0t: load_change expected %0d, got %0d",
                                 $time, want, m_load_change);
                        mismatches++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int          sent;
        int          len;
        int          center;
        int          spread;
        int          r;
        int          step_t;
        int          lo_r;
        int          hi_r;
        logic [19:0] t;
        logic [7:0]  tgt;
        logic [7:0]  tol;
        logic [23:0] per;
        logic [15:0] fb;
        logic [14:0] mc;

        set_target = TARGET_RATE_RST;
        set_tol = RATE_TOL_RST;
        set_period = UPDATE_PERIOD_RST;
        set_fallback = FALLBACK_GAIN_RST;
        set_max_change = MAX_CHANGE_RST;
        avg_q = '0;
        elapsed_q = '0;
        pending_q = 1'b0;
        rate_at_change = '0;
        gain_q = '0;
        change_q = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk: tiny gain, saturating quotient, zero dip with zero
        // fallback, zero period, unmapped indexes and the register extremes.
        for (int i = 0; i < $size(PLAN); i++) begin
            if (PLAN[i].kind == ROW_WRITE) begin
                drain_changes();
                write_reg(PLAN[i].index, PLAN[i].value);
            end else begin
                if (cfg_valid) begin
                    cfg_valid <= 1'b0;
                end
                send_sample(PLAN[i].value[15:0], PLAN[i].time_us, PLAN[i].known,
                            PLAN[i].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin tgt = 8'd60;  tol = 8'd5; per = 24'd500000; fb = 16'd256;   mc = 15'd100;   end
                1: begin tgt = 8'd255; tol = 8'd1; per = 24'd0;      fb = 16'd0;     mc = 15'h7FFF;  end
                2: begin tgt = 8'd0;   tol = 8'd0; per = 24'hFFFFFF; fb = 16'hFFFF;  mc = 15'd0;     end
                3: begin tgt = 8'd120; tol = 8'd3; per = 24'd100000; fb = 16'd64;    mc = 15'd2000;  end
                4: begin tgt = 8'd30;  tol = 8'd10; per = 24'd1;     fb = 16'd1;     mc = 15'h7FFF;  end
                default: begin
                    tgt = 8'($urandom_range(0, 255));
                    tol = 8'($urandom_range(0, 40));
                    per = 24'($urandom_range(0, 800000));
                    fb = 16'($urandom_range(0, 4096));
                    mc = 15'($urandom_range(0, 32767));
                end
            endcase
            drain_changes();
            // Bits above each register's width ride along and must be dropped (the update period write is full width).
            write_reg(REG_TARGET_RATE, {16'($urandom), tgt});
            write_reg(REG_RATE_TOL, {16'($urandom), tol});
            write_reg(REG_UPDATE_PERIOD, per);
            write_reg(REG_FALLBACK_GAIN, {8'($urandom), fb});
            write_reg(REG_MAX_CHANGE, {9'($urandom), mc});
            cfg_valid <= 1'b0;
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
                default: begin src_idle_pct = 14; sink_stall_pct = 14; end
            endcase

            lo_r = (int'(tgt) - int'(tol)) * 256;
            hi_r = (int'(tgt) + 2 * int'(tol)) * 256;
            spread = 3 * int'(tol) * 256 + 1024;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0) begin
                    len = $urandom_range(1, 4);
                    for (int j = 0; j < len; j++) begin
                        case ($urandom_range(0, 2))
                            0: t = 20'd0;
                            1: t = 20'd1000000;
                            default: t = 20'($urandom_range(0, 1000000));
                        endcase
                        send_sample(16'($urandom), t, 1'b0, 16'sd0);
                        sent++;
                    end
                end else begin
                    // A steady stretch lets the running average settle, so
                    // decisions see in-band, out-of-band and boundary values.
                    case ($urandom_range(0, 4))
                        0: center = lo_r + int'($urandom_range(0, 2)) - 1;
                        1: center = hi_r + int'($urandom_range(0, 2)) - 1;
                        4: center = int'($urandom_range(0, 65535));
                        default: center = int'(tgt) * 256
                                          + int'($urandom_range(0, 2 * spread)) - spread;
                    endcase
                    len = $urandom_range(4, 24);
                    for (int j = 0; j < len; j++) begin
                        r = center;
                        if ($urandom_range(0, 1) == 1) begin
                            r = r + int'($urandom_range(0, 128)) - 64;
                        end
                        if (r < 0) begin
                            r = 0;
                        end else if (r > 65535) begin
                            r = 65535;
                        end
                        step_t = int'(per >> $urandom_range(1, 3)) + 1;
                        if (step_t > 1000000) begin
                            step_t = 1000000;
                        end
                        t = ($urandom_range(0, 7) == 0) ? 20'd0
                            : 20'($urandom_range(step_t / 2, step_t));
                        send_sample(16'(r), t, 1'b0, 16'sd0);
                        sent++;
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    drain_changes();
                end
            end
        end

        drain_changes();
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (mismatches == 0 && due_changes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
